>>> rtl/core/pngr_pkg.sv
// Package for the patch-wise guidance rescale block.
// Holds the sizing constants, the sequencer state type and the multiplier select codes.
// No dependencies.
package pngr_pkg;

	// Buffer sizing
	localparam int MAX_PATCH_ELEMS = 64;
	localparam int IDX_W           = $clog2(MAX_PATCH_ELEMS);
	localparam int CNT_W           = IDX_W + 1;

	// Data widths
	localparam int VAL_W   = 16;
	localparam int SUM_W   = 48;
	localparam int FRAC_W  = 32;
	localparam int QUO_W   = 64;
	localparam int RATIO_W = 32;
	localparam int MUL_AW  = 16;
	localparam int MUL_BW  = 32;
	localparam int MUL_PW  = MUL_AW + MUL_BW;

	// Iteration counts of the shared divide and root steps
	localparam int DIV_STEPS  = SUM_W + FRAC_W;
	localparam int SQRT_STEPS = QUO_W / 2;
	localparam int ITER_W     = $clog2(DIV_STEPS);

	// Guidance scale after reset: 4.0 in unsigned Q4.12
	localparam logic [15:0] SCALE_RESET = 16'd16384;

	// Rounding offsets
	localparam int GUIDE_SHIFT = 12;
	localparam int OUT_SHIFT   = 16;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL_DIFF,
		S_MUL_COND,
		S_MUL_GUIDED,
		S_DIV,
		S_SQRT,
		S_EMIT,
		S_DRAIN
	} state_t;

	typedef enum logic [1:0] {
		MUL_DIFF,
		MUL_COND,
		MUL_GUIDED,
		MUL_OUT
	} mul_sel_t;

endpackage

>>> rtl/core/patch_norm_guidance_rescale.sv
// Patch-wise classifier-free guidance with norm rescaling, top level.
// Depends on pngr_pkg for constants, the state type and the multiplier select codes.
//
// Usage: a request (cond_value, uncond_value, patch_end) is taken at a rising edge
// where start is high and busy is low. Each element takes the request cycle plus
// three passes through the one shared 16x32 multiplier (guidance product, cond
// square, guided square); busy is high during the three passes. The element that
// has patch_end set, or the 64th element of a patch, closes the patch. If both
// square sums are nonzero, a bit-serial divider and then a bit-serial root run to
// form the Q16.16 norm ratio; otherwise both are skipped. The n buffered elements
// are then read from the patch buffer one per cycle and leave, one per cycle, on
// guided_value / was_rescaled / last_of_patch, each marked by result_strobe for
// one cycle, through the read register rd_s1 and then the output registers. A
// closing element keeps busy high through division, root, read-out and a drain
// state. The receiver cannot stall; results are never held. Reset (arst_n low)
// clears the sequencer, sums and element count, and sets guidance_scale to 4.0.
// Write guidance_scale with cfg_write_en only while idle; this is not enforced.
module patch_norm_guidance_rescale
	import pngr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write_en,
	input  logic [15:0]        cfg_write_data,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] cond_value,
	input  logic signed [15:0] uncond_value,
	input  logic               patch_end,
	output logic               result_strobe,
	output logic signed [15:0] guided_value,
	output logic               was_rescaled,
	output logic               last_of_patch
);

	// Sequencer
	state_t state_q, state_d;
	mul_sel_t mul_sel;

	// Configuration and request registers
	logic [15:0]        scale_q;
	logic signed [15:0] cond_q, uncond_q;
	logic               end_q;

	// Element arithmetic
	logic [31:0]        guide_prod_q;
	logic signed [15:0] guided_q;
	logic [SUM_W-1:0]   cond_acc_q, guided_acc_q;
	logic [CNT_W-1:0]   count_q, n_q, emit_idx_q;
	logic               rescale_q;

	// Patch buffer
	logic [VAL_W-1:0]   patch_mem [MAX_PATCH_ELEMS];
	logic signed [15:0] rd_s1;
	logic               rd_valid_s1, rd_last_s1;

	// Divider and root
	logic [SUM_W-1:0]   num_sh_q, rem_q;
	logic [QUO_W-1:0]   quo_q;
	logic               sat_q;
	logic [ITER_W-1:0]  iter_q;
	logic [QUO_W-1:0]   sq_n_q, sq_res_q, sq_bit_q;
	logic [RATIO_W-1:0] ratio_q;

	// Output registers
	logic               strobe_q, rescaled_q, last_q;
	logic signed [15:0] value_q;

	// Shared multiplier
	logic [MUL_AW-1:0]  mul_a;
	logic [MUL_BW-1:0]  mul_b;
	logic [MUL_PW-1:0]  mul_p;

	// Combinational helpers
	logic signed [16:0] diff;
	logic               diff_neg;
	logic [16:0]        diff_mag;
	logic [16:0]        cond_mag, guided_mag, rd_mag;
	logic [32:0]        guide_round;
	logic [19:0]        guide_p;
	logic signed [21:0] guide_sum;
	logic signed [15:0] guided_new;
	logic [SUM_W-1:0]   guided_acc_nx;
	logic               close_patch, do_rescale;
	logic               div_bit, div_ge;
	logic [SUM_W:0]     rem_sh, rem_sub;
	logic [SUM_W-1:0]   rem_nx;
	logic [QUO_W-1:0]   quo_nx, quo_final;
	logic               sat_nx;
	logic [QUO_W-1:0]   sq_t, sq_n_nx, sq_res_nx;
	logic               sq_take;
	logic [MUL_PW:0]    out_round;
	logic [32:0]        out_p;
	logic signed [15:0] out_value;

	// The one multiplier that every arithmetic pass goes through.
	assign mul_p = MUL_PW'(mul_a) * MUL_PW'(mul_b);

	// Guidance term: rounded |cond - uncond| * scale, sign restored, plus uncond, saturated.
	always_comb begin
		diff        = 17'(cond_q) - 17'(uncond_q);
		diff_neg    = diff[16];
		diff_mag    = diff_neg ? 17'(-diff) : 17'(diff);
		cond_mag    = cond_q[15] ? 17'(-17'(cond_q)) : 17'(cond_q);
		guided_mag  = guided_q[15] ? 17'(-17'(guided_q)) : 17'(guided_q);
		rd_mag      = rd_s1[15] ? 17'(-17'(rd_s1)) : 17'(rd_s1);
		guide_round = 33'(guide_prod_q) + 33'(1 << (GUIDE_SHIFT - 1));
		guide_p     = guide_round[GUIDE_SHIFT +: 20];
		guide_sum   = diff_neg ? (22'(uncond_q) - 22'(guide_p))
		                       : (22'(uncond_q) + 22'(guide_p));
		if (guide_sum > 22'sd32767) begin
			guided_new = 16'sh7FFF;
		end else if (guide_sum < -22'sd32768) begin
			guided_new = -16'sh8000;
		end else begin
			guided_new = 16'(guide_sum);
		end
	end

	// Patch close decision, taken in the guided-square pass.
	always_comb begin
		guided_acc_nx = guided_acc_q + mul_p;
		close_patch   = end_q || (count_q == CNT_W'(MAX_PATCH_ELEMS));
		do_rescale    = (cond_acc_q != '0) && (guided_acc_nx != '0);
	end

	// One step of the restoring divider: cond square sum * 2^32 / guided square sum.
	always_comb begin
		div_bit   = (iter_q >= ITER_W'(FRAC_W)) ? num_sh_q[SUM_W-1] : 1'b0;
		rem_sh    = {rem_q, div_bit};
		rem_sub   = rem_sh - {1'b0, guided_acc_q};
		div_ge    = rem_sh >= {1'b0, guided_acc_q};
		rem_nx    = div_ge ? rem_sub[SUM_W-1:0] : rem_sh[SUM_W-1:0];
		quo_nx    = {quo_q[QUO_W-2:0], div_ge};
		sat_nx    = sat_q | quo_q[QUO_W-1];
		quo_final = sat_nx ? '1 : quo_nx;
	end

	// One step of the bit-pair square root.
	always_comb begin
		sq_t      = sq_res_q + sq_bit_q;
		sq_take   = sq_n_q >= sq_t;
		sq_n_nx   = sq_take ? (sq_n_q - sq_t) : sq_n_q;
		sq_res_nx = sq_take ? ((sq_res_q >> 1) + sq_bit_q) : (sq_res_q >> 1);
	end

	// Output scaling: rounded |v| * ratio in Q16.16, sign restored, saturated; v passes unchanged without rescale.
	always_comb begin
		out_round = (MUL_PW + 1)'(mul_p) + (MUL_PW + 1)'(1 << (OUT_SHIFT - 1));
		out_p     = out_round[OUT_SHIFT +: 33];
		if (!rescale_q) begin
			out_value = rd_s1;
		end else if (rd_s1[15]) begin
			out_value = (out_p > 33'd32768) ? -16'sh8000 : 16'(-out_p[15:0]);
		end else begin
			out_value = (out_p > 33'd32767) ? 16'sh7FFF : 16'(out_p[15:0]);
		end
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) state_d = S_MUL_DIFF;
			end
			S_MUL_DIFF: state_d = S_MUL_COND;
			S_MUL_COND: state_d = S_MUL_GUIDED;
			S_MUL_GUIDED: begin
				if (!close_patch) begin
					state_d = S_IDLE;
				end else if (do_rescale) begin
					state_d = S_DIV;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_DIV: begin
				if (iter_q == '0) state_d = S_SQRT;
			end
			S_SQRT: begin
				if (iter_q == '0) state_d = S_EMIT;
			end
			S_EMIT: begin
				if (emit_idx_q + 1'b1 == n_q) state_d = S_DRAIN;
			end
			S_DRAIN: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Sequencer outputs: busy flag and multiplier operand selection.
	always_comb begin
		busy    = (state_q != S_IDLE);
		mul_sel = MUL_OUT;
		case (state_q)
			S_MUL_DIFF:   mul_sel = MUL_DIFF;
			S_MUL_COND:   mul_sel = MUL_COND;
			S_MUL_GUIDED: mul_sel = MUL_GUIDED;
			default:      mul_sel = MUL_OUT;
		endcase
		case (mul_sel)
			MUL_DIFF: begin
				mul_a = diff_mag[15:0];
				mul_b = MUL_BW'(scale_q);
			end
			MUL_COND: begin
				mul_a = cond_mag[15:0];
				mul_b = MUL_BW'(cond_mag);
			end
			MUL_GUIDED: begin
				mul_a = guided_mag[15:0];
				mul_b = MUL_BW'(guided_mag);
			end
			default: begin
				mul_a = rd_mag[15:0];
				mul_b = ratio_q;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			scale_q      <= SCALE_RESET;
			cond_acc_q   <= '0;
			guided_acc_q <= '0;
			count_q      <= '0;
			n_q          <= '0;
			emit_idx_q   <= '0;
			rescale_q    <= 1'b0;
			iter_q       <= '0;
			rd_valid_s1  <= 1'b0;
			strobe_q     <= 1'b0;
		end else begin
			state_q     <= state_d;
			rd_valid_s1 <= (state_q == S_EMIT);
			strobe_q    <= rd_valid_s1;
			if (cfg_write_en) scale_q <= cfg_write_data;
			case (state_q)
				S_MUL_COND: begin
					cond_acc_q <= cond_acc_q + mul_p;
					count_q    <= count_q + 1'b1;
				end
				S_MUL_GUIDED: begin
					if (close_patch) begin
						n_q       <= count_q;
						count_q   <= '0;
						rescale_q <= do_rescale;
						iter_q    <= ITER_W'(DIV_STEPS - 1);
					end
					if (close_patch && !do_rescale) begin
						cond_acc_q   <= '0;
						guided_acc_q <= '0;
					end else begin
						guided_acc_q <= guided_acc_nx;
					end
				end
				S_DIV: begin
					if (iter_q == '0) begin
						iter_q       <= ITER_W'(SQRT_STEPS - 1);
						cond_acc_q   <= '0;
						guided_acc_q <= '0;
					end else begin
						iter_q <= iter_q - 1'b1;
					end
				end
				S_SQRT: begin
					if (iter_q != '0) iter_q <= iter_q - 1'b1;
				end
				S_EMIT:  emit_idx_q <= emit_idx_q + 1'b1;
				S_DRAIN: emit_idx_q <= '0;
				default: begin
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cond_q   <= cond_value;
			uncond_q <= uncond_value;
			end_q    <= patch_end;
		end
		if (state_q == S_MUL_DIFF) guide_prod_q <= mul_p[31:0];
		if (state_q == S_MUL_COND) guided_q <= guided_new;
		if (state_q == S_MUL_GUIDED) begin
			num_sh_q <= cond_acc_q;
			rem_q    <= '0;
			quo_q    <= '0;
			sat_q    <= 1'b0;
		end
		if (state_q == S_DIV) begin
			num_sh_q <= num_sh_q << 1;
			rem_q    <= rem_nx;
			quo_q    <= quo_nx;
			sat_q    <= sat_nx;
			if (iter_q == '0) begin
				sq_n_q   <= quo_final;
				sq_res_q <= '0;
				sq_bit_q <= QUO_W'(1) << (QUO_W - 2);
			end
		end
		if (state_q == S_SQRT) begin
			sq_n_q   <= sq_n_nx;
			sq_res_q <= sq_res_nx;
			sq_bit_q <= sq_bit_q >> 2;
			if (iter_q == '0) ratio_q <= sq_res_nx[RATIO_W-1:0];
		end
		if (rd_valid_s1) begin
			value_q    <= out_value;
			rescaled_q <= rescale_q;
			last_q     <= rd_last_s1;
		end
	end

	// Patch buffer: written in the cond-square pass, read during read-out.
	always_ff @(posedge clk) begin
		if (state_q == S_MUL_COND) patch_mem[count_q[IDX_W-1:0]] <= guided_new;
		if (state_q == S_EMIT) begin
			rd_s1      <= patch_mem[emit_idx_q[IDX_W-1:0]];
			rd_last_s1 <= (emit_idx_q + 1'b1 == n_q);
		end
	end

	assign result_strobe = strobe_q;
	assign guided_value  = value_q;
	assign was_rescaled  = rescaled_q;
	assign last_of_patch = last_q;

`ifndef SYNTH
	// A request always starts a busy period.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after an accepted request");

	// The divider never runs with a zero divisor.
	a_div_den: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> guided_acc_q != '0)
		else $error("division started with a zero guided sum");

	// The element count never passes the buffer depth.
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_PATCH_ELEMS))
		else $error("element count beyond buffer depth");

	// Every result follows a valid buffer read register (rd_valid_s1) in the cycle before.
	a_strobe_src: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> $past(rd_valid_s1))
		else $error("result strobe without a buffer read");
`endif

endmodule
